@@ design/tbs_pkg.sv @@
package tbs_pkg;

    // Field widths
    localparam int LEN_W        = 16;
    localparam int NOW_W        = 32;
    localparam int RATE_W       = 30;
    localparam int OUT_CREDIT_W = 40;
    localparam int DELAY_W      = 31;

    // Configuration port
    localparam int CFG_IDX_W    = 8;
    localparam int CFG_DATA_W   = 32;

    localparam logic [CFG_IDX_W-1:0] REG_LIMIT_ENABLED = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_RATE_LIMIT    = CFG_IDX_W'(1);

    localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(1000);

    // Parameter defaults
    localparam int CREDIT_BITS_DEF = 40;
    localparam int TIME_BITS_DEF   = 32;

    localparam logic [DELAY_W-1:0] DELAY_MAX = {DELAY_W{1'b1}};

    // x * 1000 = (x << 10) - (x << 5) + (x << 3)
    localparam int MS_SH_HI  = 10;
    localparam int MS_SH_MID = 5;
    localparam int MS_SH_LO  = 3;

    // Step counter, wide enough for the longest sweep (divide)
    localparam int CNT_W = 5;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ELAP,
        S_MUL,
        S_ADDC,
        S_CAP,
        S_CRED,
        S_NEG,
        S_M1A,
        S_M1B,
        S_SAT,
        S_DIV,
        S_DONE
    } t_state;

endpackage

@@ design/tbs_if.sv @@
interface tbs_in_if import tbs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [LEN_W-1:0] packet_length;
    logic [NOW_W-1:0] now_seconds;

    modport source (output valid, output packet_length, output now_seconds, input ready);
    modport sink   (input valid, input packet_length, input now_seconds, output ready);
endinterface

interface tbs_out_if import tbs_pkg::*; ();
    logic                           valid;
    logic                           ready;
    logic                           unlimited;
    logic signed [OUT_CREDIT_W-1:0] available_credit;
    logic        [DELAY_W-1:0]      delay_ms;

    modport source (output valid, output unlimited, output available_credit,
                    output delay_ms, input ready);
    modport sink   (input valid, input unlimited, input available_credit,
                    input delay_ms, output ready);
endinterface

interface tbs_cfg_if import tbs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ design/token_bucket_send_shaper.sv @@
// Channel  Dir  Payload                                      Transfer
// i_in     in   packet_length, now_seconds                   valid && ready
// o_out    out  unlimited, available_credit, delay_ms        valid && ready
// i_cfg    in   index, data (0: limit_enabled, 1: rate_limit) valid && ready, ready tied 1
//
// Limiting off: an item goes straight to the output step. Limiting on: the work is set
// by the 30-step shift-add multiply and, when a delay must be computed, the 31-step
// restoring divide, both run on the one shared adder.
// Reset (i_rst_n low, synchronous) clears credit and time reference and resets configuration.
// A finished result waits in the output register; the next item is taken meanwhile,
// but the sequencer holds in its last step until the output register is free.
module token_bucket_send_shaper import tbs_pkg::*; #(
    parameter int CREDIT_BITS = CREDIT_BITS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tbs_in_if.sink    i_in,
    tbs_out_if.source o_out,
    tbs_cfg_if.sink   i_cfg
);

    localparam int CB = CREDIT_BITS;
    localparam int TB = TIME_BITS;

    // Adder width: product e*r, dividend diff*1000, and rate << DELAY_W
    localparam int W_MUL = TB + RATE_W + 2;
    localparam int W_DVD = CB + MS_SH_HI + 2;
    localparam int W_SAT = RATE_W + DELAY_W + 2;
    localparam int W_A   = W_MUL > W_DVD ? W_MUL : W_DVD;
    localparam int W     = W_A > W_SAT ? W_A : W_SAT;

    localparam int EXT_W = CB > OUT_CREDIT_W ? CB : OUT_CREDIT_W;

    localparam logic signed [CB-1:0] CREDIT_MIN = {1'b1, {(CB-1){1'b0}}};

    t_state r_state, n_state;

    logic                 r_en;
    logic [RATE_W-1:0]    r_rate;

    logic [LEN_W-1:0]     r_len, n_len;
    logic [TB-1:0]        r_now, n_now;
    logic [TB-1:0]        r_last, n_last;
    logic                 r_tv, n_tv;
    logic signed [CB-1:0] r_credit, n_credit;
    logic signed [CB-1:0] r_avail, n_avail;
    logic [W-1:0]         r_acc, n_acc;
    logic [W-1:0]         r_opd, n_opd;
    logic [DELAY_W-1:0]   r_q, n_q;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic                 r_unl, n_unl;

    logic                           r_o_valid;
    logic                           r_o_unl;
    logic signed [OUT_CREDIT_W-1:0] r_o_credit;
    logic [DELAY_W-1:0]             r_o_delay;

    logic                    w_load;
    logic                    w_fits;
    logic signed [EXT_W-1:0] w_avail_ext;

    // Shared add/subtract unit
    logic [W-1:0] u_a, u_b, u_res;
    logic         u_sub;

    assign u_res = u_sub ? (u_a - u_b) : (u_a + u_b);

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid            = r_o_valid;
    assign o_out.unlimited        = r_o_unl;
    assign o_out.available_credit = r_o_credit;
    assign o_out.delay_ms         = r_o_delay;

    assign w_avail_ext = EXT_W'(r_avail);
    assign w_fits      = (&u_res[W-1:CB-1]) | ~(|u_res[W-1:CB-1]);

    always_comb begin
        n_state  = r_state;
        n_len    = r_len;
        n_now    = r_now;
        n_last   = r_last;
        n_tv     = r_tv;
        n_credit = r_credit;
        n_avail  = r_avail;
        n_acc    = r_acc;
        n_opd    = r_opd;
        n_q      = r_q;
        n_cnt    = r_cnt;
        n_unl    = r_unl;
        w_load   = 1'b0;
        u_a      = r_acc;
        u_b      = r_opd;
        u_sub    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_len = i_in.packet_length;
                    n_now = TB'(i_in.now_seconds);
                    n_unl = ~r_en;
                    if (r_en) begin
                        n_state = S_ELAP;
                    end else begin
                        n_avail = '0;
                        n_q     = '0;
                        n_state = S_DONE;
                    end
                end
            end
            S_ELAP: begin
                // elapsed time wraps; the first item only sets the reference
                u_a    = W'(r_now);
                u_b    = W'(r_last);
                u_sub  = 1'b1;
                n_opd  = r_tv ? W'(u_res[TB-1:0]) : '0;
                n_last = r_now;
                n_tv   = 1'b1;
                n_acc  = '0;
                n_cnt  = CNT_W'(RATE_W - 1);
                n_state = S_MUL;
            end
            S_MUL: begin
                // elapsed * rate, MSB of rate first
                u_a   = r_acc << 1;
                u_b   = r_rate[r_cnt] ? r_opd : '0;
                n_acc = u_res;
                if (r_cnt == '0) begin
                    n_state = S_ADDC;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_ADDC: begin
                u_a     = r_acc;
                u_b     = W'(r_credit);
                n_acc   = u_res;
                n_state = S_CAP;
            end
            S_CAP: begin
                // cap the refilled credit at the rate
                u_a   = r_acc;
                u_b   = W'(r_rate);
                u_sub = 1'b1;
                if (u_res[W-1]) begin
                    n_avail = r_acc[CB-1:0];
                end else begin
                    n_avail = CB'(r_rate);
                end
                n_state = S_CRED;
            end
            S_CRED: begin
                u_a      = W'(r_avail);
                u_b      = W'(r_len);
                u_sub    = 1'b1;
                n_credit = w_fits ? u_res[CB-1:0] : CREDIT_MIN;
                n_acc    = u_res;
                if (!u_res[W-1]) begin
                    n_q     = '0;
                    n_state = S_DONE;
                end else if (r_rate == '0) begin
                    n_q     = DELAY_MAX;
                    n_state = S_DONE;
                end else begin
                    n_state = S_NEG;
                end
            end
            S_NEG: begin
                // shortfall = len - available credit
                u_a     = '0;
                u_b     = r_acc;
                u_sub   = 1'b1;
                n_acc   = u_res;
                n_state = S_M1A;
            end
            S_M1A: begin
                u_a     = r_acc << MS_SH_HI;
                u_b     = r_acc << MS_SH_MID;
                u_sub   = 1'b1;
                n_opd   = u_res;
                n_state = S_M1B;
            end
            S_M1B: begin
                u_a     = r_opd;
                u_b     = r_acc << MS_SH_LO;
                n_acc   = u_res;
                n_state = S_SAT;
            end
            S_SAT: begin
                // a quotient of 2^31 or more saturates
                u_a   = r_acc;
                u_b   = W'(r_rate) << DELAY_W;
                u_sub = 1'b1;
                if (!u_res[W-1]) begin
                    n_q     = DELAY_MAX;
                    n_state = S_DONE;
                end else begin
                    n_q     = '0;
                    n_cnt   = CNT_W'(DELAY_W - 1);
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                u_a   = r_acc;
                u_b   = W'(r_rate) << r_cnt;
                u_sub = 1'b1;
                if (!u_res[W-1]) begin
                    n_acc = u_res;
                end
                n_q = {r_q[DELAY_W-2:0], ~u_res[W-1]};
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                end
            end
            S_DONE: begin
                if (!r_o_valid || o_out.ready) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_last   <= '0;
            r_tv     <= 1'b0;
            r_credit <= '0;
        end else begin
            r_state  <= n_state;
            r_last   <= n_last;
            r_tv     <= n_tv;
            r_credit <= n_credit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len   <= n_len;
        r_now   <= n_now;
        r_avail <= n_avail;
        r_acc   <= n_acc;
        r_opd   <= n_opd;
        r_q     <= n_q;
        r_cnt   <= n_cnt;
        r_unl   <= n_unl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en   <= 1'b0;
            r_rate <= RATE_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_LIMIT_ENABLED: r_en   <= i_cfg.data[0];
                REG_RATE_LIMIT:    r_rate <= i_cfg.data[RATE_W-1:0];
                default:           ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (w_load) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_unl    <= r_unl;
            r_o_credit <= w_avail_ext[OUT_CREDIT_W-1:0];
            r_o_delay  <= r_q;
        end
    end

`ifndef SYNTH
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input taken again while an item is in flight");

    a_ref_from_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_tv) |-> $past(r_state) == S_ELAP)
        else $error("time reference set outside an item");

    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(r_state) == S_DONE)
        else $error("result presented without a finished item");

    a_unlimited_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.unlimited |->
            o_out.available_credit == '0 && o_out.delay_ms == '0)
        else $error("unlimited result carries credit or delay");
`endif

endmodule

@@ tb/tb_token_bucket_send_shaper.sv @@
`timescale 1ns / 1ps

module tb_token_bucket_send_shaper;
    import tbs_pkg::*;

    localparam int             DRAIN_CYCLES = 80;
    localparam int             RAND_PHASES  = 10;
    localparam int             PHASE_PKTS   = 180;
    localparam longint unsigned MS_PER_SEC  = 1000;
    localparam logic [RATE_W-1:0] RATE_TOP  = {RATE_W{1'b1}};
    localparam logic [RATE_W-1:0] RATE_GIGA = RATE_W'(1000000000);

    typedef struct packed {
        logic [LEN_W-1:0] len;
        logic [NOW_W-1:0] now;
    } t_packet;

    typedef struct packed {
        logic                    unlimited;
        logic [OUT_CREDIT_W-1:0] available_credit;
        logic [DELAY_W-1:0]      delay_ms;
    } t_shaper_result;

    logic i_clk;
    logic i_rst_n;

    tbs_in_if  pkt_if ();
    tbs_out_if res_if ();
    tbs_cfg_if cfg_if ();

    token_bucket_send_shaper u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (pkt_if),
        .o_out   (res_if),
        .i_cfg   (cfg_if)
    );

    // Shaper model state and its copy of the registers
    bit                shape_enabled = 1'b0;
    bit [RATE_W-1:0]   shape_rate    = RATE_RESET;
    longint            credit_bal    = 0;
    bit [NOW_W-1:0]    ref_time      = '0;
    bit                time_known    = 1'b0;

    t_packet        pending_pkts[$];
    t_shaper_result expected_q[$];
    t_packet        launch_pkt;
    t_shaper_result exp_out;
    int             send_gap;
    int             stall_left;
    bit             idling_on = 1'b1;
    int             mismatches = 0;

    function automatic t_shaper_result shape_packet(input logic [LEN_W-1:0] len,
                                                    input logic [NOW_W-1:0] now);
        t_shaper_result  res;
        logic [NOW_W-1:0] gap_s;
        longint unsigned elapsed, deficit, add, diff, q, rem, d, rate_u;
        longint          cap, avail, floor_val, len_s;
        res = '0;
        if (!shape_enabled) begin
            res.unlimited = 1'b1;
            return res;
        end
        gap_s      = now - ref_time;
        elapsed    = time_known ? 64'(gap_s) : 64'd0;
        ref_time   = now;
        time_known = 1'b1;

        rate_u    = 64'(shape_rate);
        cap       = longint'(rate_u);
        len_s     = longint'(64'(len));
        floor_val = -(longint'(1) <<< (CREDIT_BITS_DEF - 1));

        // refill, capped at the rate even when nothing elapsed
        if (credit_bal >= cap) begin
            avail = cap;
        end else begin
            deficit = cap - credit_bal;
            if (rate_u == 0) begin
                avail = credit_bal;
            end else if (elapsed > deficit / rate_u) begin
                avail = cap;
            end else begin
                add   = elapsed * rate_u;
                avail = (add >= deficit) ? cap : credit_bal + longint'(add);
            end
        end

        if (avail < floor_val + len_s)
            credit_bal = floor_val;
        else
            credit_bal = avail - len_s;

        d = 0;
        if (len_s > avail) begin
            diff = len_s - avail;
            if (rate_u == 0) begin
                d = 64'(DELAY_MAX);
            end else begin
                q   = diff / rate_u;
                rem = diff % rate_u;
                if (q > 64'(DELAY_MAX) / MS_PER_SEC) begin
                    d = 64'(DELAY_MAX);
                end else begin
                    d = q * MS_PER_SEC + (rem * MS_PER_SEC) / rate_u;
                    if (d > 64'(DELAY_MAX))
                        d = 64'(DELAY_MAX);
                end
            end
        end

        res.available_credit = avail[OUT_CREDIT_W-1:0];
        res.delay_ms         = d[DELAY_W-1:0];
        return res;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Packet driver: hold each packet until its transfer, idle in bursts
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pkt_if.valid <= 1'b0;
            send_gap = 0;
        end else begin
            if (pkt_if.valid && pkt_if.ready)
                expected_q.push_back(shape_packet(pkt_if.packet_length, pkt_if.now_seconds));
            if (!pkt_if.valid || pkt_if.ready) begin
                if (send_gap == 0 && idling_on && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 11);
                if (send_gap > 0 || pending_pkts.size() == 0) begin
                    if (send_gap > 0)
                        send_gap--;
                    pkt_if.valid <= 1'b0;
                end else begin
                    launch_pkt = pending_pkts.pop_front();
                    pkt_if.valid         <= 1'b1;
                    pkt_if.packet_length <= launch_pkt.len;
                    pkt_if.now_seconds   <= launch_pkt.now;
                end
            end
        end
    end

    // Result monitor: stall in bursts, check each transfer against the oldest prediction
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_q.size() == 0) begin
                    $error("result transfer with no prediction waiting");
                    mismatches++;
                end else begin
                    exp_out = expected_q.pop_front();
                    if (res_if.unlimited !== exp_out.unlimited) begin
                        $error("unlimited: expected %0d, got %0d",
                               exp_out.unlimited, res_if.unlimited);
                        mismatches++;
                    end
                    if (res_if.available_credit !== exp_out.available_credit) begin
                        $error("available_credit: expected %0d, got %0d",
                               $signed(exp_out.available_credit),
                               $signed(res_if.available_credit));
                        mismatches++;
                    end
                    if (res_if.delay_ms !== exp_out.delay_ms) begin
                        $error("delay_ms: expected %0d, got %0d",
                               exp_out.delay_ms, res_if.delay_ms);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0)
                stall_left--;
            else if (idling_on && $urandom_range(0, 5) == 0)
                stall_left = $urandom_range(1, 11);
            res_if.ready <= (stall_left == 0);
        end
    end

    task automatic queue_packet(input logic [LEN_W-1:0] len, input logic [NOW_W-1:0] now);
        t_packet p;
        p.len = len;
        p.now = now;
        pending_pkts.push_back(p);
    endtask

    // Wait until every packet has been sent and answered, then let the block settle
    task automatic settle_shaper();
        do
            @(negedge i_clk);
        while (pending_pkts.size() != 0 || pkt_if.valid || expected_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= value;
        do
            @(posedge i_clk);
        while (!cfg_if.ready);
        if (idx == REG_LIMIT_ENABLED)
            shape_enabled = value[0];
        else if (idx == REG_RATE_LIMIT)
            shape_rate = value[RATE_W-1:0];
        cfg_if.valid <= 1'b0;
    endtask

    initial begin : stimulus
        int              ph, k, len_top;
        bit [RATE_W-1:0] rate_sel;
        bit [NOW_W-1:0]  clock_s;
        bit [LEN_W-1:0]  len_v;

        i_rst_n              = 1'b0;
        pkt_if.valid         = 1'b0;
        pkt_if.packet_length = '0;
        pkt_if.now_seconds   = '0;
        res_if.ready         = 1'b0;
        cfg_if.valid         = 1'b0;
        cfg_if.index         = '0;
        cfg_if.data          = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // limiting off after reset
        queue_packet(16'd0, 32'd0);
        queue_packet(16'hFFFF, 32'hFFFF_FFFF);
        queue_packet(16'd1500, 32'h5555_AAAA);
        settle_shaper();

        program_reg(REG_RATE_LIMIT, 32'd1000);
        program_reg(REG_LIMIT_ENABLED, 32'd1);
        // first packet only takes the time reference
        queue_packet(16'd100, 32'd5);
        queue_packet(16'd0, 32'd5);
        queue_packet(16'd500, 32'd6);
        queue_packet(16'hFFFF, 32'd1000);
        // time wraps past the top
        queue_packet(16'd200, 32'hFFFF_FFFE);
        queue_packet(16'd300, 32'hFFFF_FFFF);
        queue_packet(16'd700, 32'd2);
        queue_packet(16'd1000, 32'h7FFF_FFFF);
        queue_packet(16'd0, 32'h8000_0000);
        settle_shaper();

        // credit above a lowered rate is clipped without any elapsed time
        program_reg(REG_RATE_LIMIT, 32'd10);
        queue_packet(16'd3, 32'h8000_0000);
        queue_packet(16'd20, 32'h8000_0001);
        settle_shaper();

        program_reg(REG_RATE_LIMIT, 32'd0);
        queue_packet(16'd0, 32'h8000_0005);
        queue_packet(16'd1, 32'h8000_0005);
        settle_shaper();

        // deep deficit at the lowest nonzero rate drives the delay into saturation
        program_reg(REG_RATE_LIMIT, 32'd1);
        for (k = 0; k < 36; k++)
            queue_packet(16'hFFFF, 32'h8000_0005);
        settle_shaper();

        program_reg(REG_RATE_LIMIT, 32'(RATE_TOP));
        queue_packet(16'hFFFF, 32'h8000_0006);
        queue_packet(16'hFFFF, 32'h8000_0006);
        settle_shaper();
        program_reg(REG_RATE_LIMIT, 32'(RATE_GIGA));
        queue_packet(16'd0, 32'h8000_0007);
        settle_shaper();

        // state must hold while limiting is off
        program_reg(REG_LIMIT_ENABLED, 32'd0);
        queue_packet(16'd500, 32'h0000_0001);
        settle_shaper();
        program_reg(REG_LIMIT_ENABLED, 32'd1);
        queue_packet(16'd100, 32'h8000_0007);
        settle_shaper();

        clock_s = 32'h8000_0008;
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 7))
                0: rate_sel = 30'd1;
                1: rate_sel = 30'($urandom_range(2, 100));
                2, 3: rate_sel = 30'($urandom_range(500, 2000));
                4: rate_sel = 30'($urandom_range(2000, 100000));
                5: rate_sel = 30'($urandom_range(100000, 1000000000));
                6: rate_sel = RATE_GIGA;
                default: rate_sel = RATE_TOP;
            endcase
            if (ph == 5)
                rate_sel = '0;
            program_reg(REG_RATE_LIMIT, 32'(rate_sel));
            program_reg(REG_LIMIT_ENABLED, (ph % 4 == 3) ? 32'd0 : 32'd1);
            idling_on = (ph != RAND_PHASES - 1);
            len_top = (rate_sel < 30'd32768) ? 2 * int'(rate_sel) + 1 : 65535;
            for (k = 0; k < PHASE_PKTS; k++) begin
                case ($urandom_range(0, 15))
                    0, 1, 2, 3, 4, 5, 6, 7: clock_s = clock_s + $urandom_range(0, 1);
                    8, 9, 10, 11:           clock_s = clock_s + $urandom_range(2, 20);
                    12:                     clock_s = clock_s + $urandom;
                    13:                     clock_s = $urandom;
                    14:                     clock_s = 32'hFFFF_FFFF - $urandom_range(0, 3);
                    default: ;
                endcase
                case ($urandom_range(0, 7))
                    0: len_v = '0;
                    1: len_v = '1;
                    2, 3: len_v = 16'($urandom_range(0, 65535));
                    default: len_v = 16'($urandom_range(0, len_top));
                endcase
                queue_packet(len_v, clock_s);
            end
            settle_shaper();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("token_bucket_send_shaper regression: pass");
        else
            $display("token_bucket_send_shaper regression: fail");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("token_bucket_send_shaper regression: fail");
        $finish;
    end

endmodule
